>>> rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/wsd_pkg.sv
// Types and constants shared by the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

    localparam int unsigned LIMIT_W = 48;
    localparam int unsigned CHUNK_W = 21;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT   = 2'd2;

    localparam logic [LIMIT_W-1:0] MESSAGE_LIMIT_RST = 48'd16777216;
    localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_RST   = 21'd65536;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_STREAM_END = 2'd1;
    localparam logic [1:0] ERR_LIMIT      = 2'd2;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } in_beat_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [3:0] message_opcode;
        logic       frame_end;
        logic       message_end;
        logic       chunk_end;
        logic [1:0] error_code;
    } out_beat_t;

    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_MARK = 2'd1,
        CMD_ERR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic [3:0] opcode;
        logic       last;
        logic       msg_end;
        logic [1:0] err;
    } cmd_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] message_limit;
        logic               limit_enable;
    } front_cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/wsd_front.sv
// Header parser: classifies each received byte and issues payload, marker or error commands.
`default_nettype none
`include "assert_macros.svh"
module wsd_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire wsd_pkg::in_beat_t s_beat,
    input  wire wsd_pkg::front_cfg_t cfg,
    input  wire logic              q_full,
    output logic                   push,
    output wsd_pkg::cmd_t          cmd
);

    typedef enum logic [4:0] {
        PH_HDR1 = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        final_reg, final_next;
    logic        masked_reg, masked_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  key_left_reg, key_left_next;
    logic [63:0] pl_reg, pl_next;
    logic [1:0]  pos_reg, pos_next;
    logic [63:0] total_reg, total_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [7:0]  b;
    logic        ended;
    logic [6:0]  len7;
    logic [63:0] body_len;
    logic [64:0] sum_raw;
    logic [63:0] sum_sat;
    logic        over;
    logic        body_go;
    logic [63:0] pl_dec;
    logic        last;
    logic        msg_end;
    logic [7:0]  key_sel;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign b       = s_beat.stream_byte;
    assign ended   = s_beat.stream_end;
    assign len7    = b[6:0];

    // Frame length as it stands once the current byte closes the header.
    always_comb begin
        case (phase_reg)
            PH_HDR2: body_len = {57'd0, len7};
            PH_EXT:  body_len = {acc_reg[55:0], b};
            default: body_len = acc_reg;
        endcase
    end

    assign sum_raw = {1'b0, total_reg} + {1'b0, body_len};
    assign sum_sat = sum_raw[64] ? {64{1'b1}} : sum_raw[63:0];
    assign over    = (body_len != 64'd0) && cfg.limit_enable
                     && (sum_sat > {16'd0, cfg.message_limit});

    assign pl_dec  = pl_reg - 64'd1;
    assign last    = (pl_dec == 64'd0);
    assign msg_end = last && final_reg;

    always_comb begin
        case (pos_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        final_next    = final_reg;
        masked_next   = masked_reg;
        opcode_next   = opcode_reg;
        len_left_next = len_left_reg;
        acc_next      = acc_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        pl_next       = pl_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        halted_next   = halted_reg;
        push          = 1'b0;
        cmd           = '0;
        body_go       = 1'b0;

        if (accept && !halted_reg) begin
            case (phase_reg)
                PH_HDR2: begin
                    masked_next = b[7];
                    acc_next    = 64'd0;
                    if (len7 == 7'd126 || len7 == 7'd127) begin
                        len_left_next = (len7 == 7'd126) ? 4'd2 : 4'd8;
                        phase_next    = PH_EXT;
                        push          = ended;
                    end else begin
                        acc_next = {57'd0, len7};
                        if (b[7]) begin
                            key_left_next = 3'd4;
                            phase_next    = PH_KEY;
                            push          = ended;
                        end else begin
                            body_go = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    acc_next      = {acc_reg[55:0], b};
                    len_left_next = len_left_reg - 4'd1;
                    if (len_left_next != 4'd0) begin
                        push = ended;
                    end else if (masked_reg) begin
                        key_left_next = 3'd4;
                        phase_next    = PH_KEY;
                        push          = ended;
                    end else begin
                        body_go = 1'b1;
                    end
                end
                PH_KEY: begin
                    key_next      = {key_reg[23:0], b};
                    key_left_next = key_left_reg - 3'd1;
                    if (key_left_next != 3'd0) begin
                        push = ended;
                    end else begin
                        body_go = 1'b1;
                    end
                end
                PH_DATA: begin
                    pl_next  = pl_dec;
                    pos_next = pos_reg + 2'd1;
                    if (last) begin
                        phase_next = PH_HDR1;
                        if (msg_end) begin
                            total_next = 64'd0;
                        end
                    end
                    push = 1'b1;
                    if (!(ended && !msg_end)) begin
                        cmd.kind     = wsd_pkg::CMD_DATA;
                        cmd.raw_byte = b;
                        cmd.key_byte = masked_reg ? key_sel : 8'd0;
                        cmd.last     = last;
                        cmd.msg_end  = msg_end;
                    end
                end
                default: begin
                    final_next = b[7];
                    if (b[3:0] != 4'd0) begin
                        opcode_next = b[3:0];
                    end
                    phase_next = PH_HDR2;
                    push       = ended;
                end
            endcase

            // Header complete: load the body counters and check the message size.
            if (body_go) begin
                pl_next  = body_len;
                pos_next = 2'd0;
                if (over) begin
                    push     = 1'b1;
                    cmd.kind = wsd_pkg::CMD_ERR;
                    cmd.err  = wsd_pkg::ERR_LIMIT;
                end else begin
                    total_next = sum_sat;
                    if (body_len == 64'd0) begin
                        phase_next = PH_HDR1;
                        if (final_reg) begin
                            total_next  = 64'd0;
                            push        = 1'b1;
                            cmd.kind    = wsd_pkg::CMD_MARK;
                            cmd.last    = 1'b1;
                            cmd.msg_end = 1'b1;
                        end else begin
                            push = ended;
                        end
                    end else begin
                        phase_next = PH_DATA;
                        push       = ended;
                    end
                end
            end

            // Any beat that pushes without a data or marker command is an error.
            if (push && !(cmd.kind == wsd_pkg::CMD_DATA && phase_reg == PH_DATA
                          && !(ended && !msg_end))
                     && cmd.kind != wsd_pkg::CMD_MARK) begin
                if (cmd.kind != wsd_pkg::CMD_ERR) begin
                    cmd.kind = wsd_pkg::CMD_ERR;
                    cmd.err  = wsd_pkg::ERR_STREAM_END;
                end
                cmd.raw_byte = 8'd0;
                cmd.key_byte = 8'd0;
                cmd.last     = 1'b0;
                cmd.msg_end  = 1'b0;
                halted_next  = 1'b1;
            end
        end
        cmd.opcode = opcode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR1;
            final_reg    <= 1'b0;
            masked_reg   <= 1'b0;
            opcode_reg   <= 4'd0;
            len_left_reg <= 4'd0;
            acc_reg      <= 64'd0;
            key_reg      <= 32'd0;
            key_left_reg <= 3'd0;
            pl_reg       <= 64'd0;
            pos_reg      <= 2'd0;
            total_reg    <= 64'd0;
            halted_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            final_reg    <= final_next;
            masked_reg   <= masked_next;
            opcode_reg   <= opcode_next;
            len_left_reg <= len_left_next;
            acc_reg      <= acc_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            pl_reg       <= pl_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            halted_reg   <= halted_next;
        end
    end

    `ASSERT_NEXT(fr_halt_sticky, aclk, aresetn, halted_reg, halted_reg)
    `ASSERT_NEXT(fr_err_halts, aclk, aresetn, push && cmd.kind == wsd_pkg::CMD_ERR, halted_reg)
    `ASSERT_IMPLY(fr_quiet_halted, aclk, aresetn, halted_reg, !push)

endmodule
`default_nettype wire

>>> rtl/core/wsd_queue.sv
// Short command queue between the header parser and the output stage.
`default_nettype none
`include "assert_macros.svh"
module wsd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire wsd_pkg::cmd_t wr_cmd,
    input  wire logic          pop,
    output wsd_pkg::cmd_t      rd_cmd,
    output logic               not_empty,
    output logic               full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsd_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign rd_cmd    = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_FULL);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLY(q_no_overflow, aclk, aresetn, push, count_reg != CNT_FULL)
    `ASSERT_IMPLY(q_no_underflow, aclk, aresetn, pop, count_reg != '0)

endmodule
`default_nettype wire

>>> rtl/core/wsd_back.sv
// Output stage: unmasks payload, tracks chunk boundaries and holds the result beat.
`default_nettype none
module wsd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire wsd_pkg::cmd_t                 q_cmd,
    output logic                               pop,
    input  wire logic [wsd_pkg::CHUNK_W-1:0]   chunk_limit,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output wsd_pkg::out_beat_t                 m_data
);

    logic                        m_valid_reg, m_valid_next;
    wsd_pkg::out_beat_t          m_data_reg, m_data_next;
    logic [wsd_pkg::CHUNK_W-1:0] cnt_reg, cnt_next;
    logic [wsd_pkg::CHUNK_W-1:0] cnt_inc;
    logic [wsd_pkg::CHUNK_W-1:0] lim;
    logic                        ce;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pop     = q_valid && (!m_valid_reg || m_ready);

    // A zero chunk limit behaves as one byte per chunk.
    assign lim     = (chunk_limit == '0) ? wsd_pkg::CHUNK_W'(1) : chunk_limit;
    assign cnt_inc = cnt_reg + wsd_pkg::CHUNK_W'(1);
    assign ce      = q_cmd.last || (cnt_inc >= lim);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cnt_next     = cnt_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next               = 1'b1;
            m_data_next                = '0;
            m_data_next.message_opcode = q_cmd.opcode;
            case (q_cmd.kind)
                wsd_pkg::CMD_DATA: begin
                    m_data_next.payload_valid = 1'b1;
                    m_data_next.payload_byte  = q_cmd.raw_byte ^ q_cmd.key_byte;
                    m_data_next.frame_end     = q_cmd.last;
                    m_data_next.message_end   = q_cmd.msg_end;
                    m_data_next.chunk_end     = ce;
                    cnt_next                  = ce ? '0 : cnt_inc;
                end
                wsd_pkg::CMD_MARK: begin
                    m_data_next.frame_end   = 1'b1;
                    m_data_next.message_end = 1'b1;
                end
                default: begin
                    m_data_next.error_code = q_cmd.err;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/websocket_frame_deframer.sv
// Each payload byte, end marker or error is held in the queue, then in the output register.
// One byte per cycle while s_ready; header bytes yield only error or end-marker beats.
// The header parser and the output register are split by a short queue, so s_ready
// depends only on queue fill and never on m_ready in the same cycle.
// Reset: synchronous, active low; clears parser state and halt, reloads register defaults.
// No clearing pass: the block takes input as soon as reset is released.
`default_nettype none
module websocket_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire wsd_pkg::in_beat_t                s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output wsd_pkg::out_beat_t                    m_data,
    input  wire logic                             cfg_wen,
    input  wire logic [wsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wsd_pkg::LIMIT_W-1:0]      cfg_wdata
);

    logic [wsd_pkg::LIMIT_W-1:0] message_limit_reg;
    logic                        limit_enable_reg;
    logic [wsd_pkg::CHUNK_W-1:0] chunk_limit_reg;

    wsd_pkg::front_cfg_t front_cfg;
    wsd_pkg::cmd_t       push_cmd;
    wsd_pkg::cmd_t       pop_cmd;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            message_limit_reg <= wsd_pkg::MESSAGE_LIMIT_RST;
            limit_enable_reg  <= 1'b1;
            chunk_limit_reg   <= wsd_pkg::CHUNK_LIMIT_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                wsd_pkg::CFG_MESSAGE_LIMIT: message_limit_reg <= cfg_wdata;
                wsd_pkg::CFG_LIMIT_ENABLE:  limit_enable_reg  <= cfg_wdata[0];
                wsd_pkg::CFG_CHUNK_LIMIT:   chunk_limit_reg   <= cfg_wdata[wsd_pkg::CHUNK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign front_cfg.message_limit = message_limit_reg;
    assign front_cfg.limit_enable  = limit_enable_reg;

    wsd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_data),
        .cfg     (front_cfg),
        .q_full  (q_full),
        .push    (push),
        .cmd     (push_cmd)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_cmd    (push_cmd),
        .pop       (pop),
        .rd_cmd    (pop_cmd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    wsd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_not_empty),
        .q_cmd       (pop_cmd),
        .pop         (pop),
        .chunk_limit (chunk_limit_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire
